// ----- src/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants for the stable insertion sorter
// Entry and result layouts, sizes of the insertion row and the input queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  // Entries held by the insertion row
  localparam int CAPACITY    = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Entries buffered between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One incoming entry
  typedef struct packed {
    logic signed [31:0] key;
    logic        [15:0] neighbor_id;
    logic        [15:0] edge_id;
    logic               last_in;
  } in_item_t;

  // One sorted result
  typedef struct packed {
    logic signed [31:0] sorted_key;
    logic        [15:0] sorted_neighbor;
    logic        [15:0] sorted_edge;
    logic               last_out;
    logic               overflow;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/stable_insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// stable_insertion_sorter: stable ascending sort of runs of keyed entries
// A front queue feeds a systolic insertion row; sorted runs leave through a
// registered result slot.
//
//   Channel   Handshake           Payload
//   entries   push / full         item   (in_item_t)
//   results   pop / empty         result (out_item_t)
//
// The row inserts one entry per cycle while filling: all cells compare in parallel.
// After the entry marked last, the run drains one result per cycle from the
// head of the row; entries pushed meanwhile wait in the 4-deep front queue,
// so the row takes no new entry until all N stored entries of the run have left.
// Entries beyond 16 in a run are dropped and flag overflow on its results.
// Reset (rst, synchronous) empties the queue, the row and the result slot.
// A stalled pop holds the result slot and backs up the drain, then the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_insertion_sorter
  import sis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire in_item_t item,
  output logic          full,
  output logic          empty,
  output out_item_t     result,
  input  wire logic     pop
);

  logic       q_valid;
  in_item_t   q_item;
  logic       q_pop;
  logic       d_valid;
  out_item_t  d_item;
  logic       d_take;
  logic       res_valid;

  sis_in_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  sis_insert_row u_row (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .d_valid (d_valid),
    .d_item  (d_item),
    .d_take  (d_take)
  );

  // Result slot: refills in the cycle its transaction completes
  assign empty  = !res_valid;
  assign d_take = d_valid && (!res_valid || pop);

  always_ff @(posedge clk) begin
    if (d_take) begin
      result <= d_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (d_take) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- src/sis_in_queue.sv -----
// ----------------------------------------------------------------------------
// sis_in_queue: front queue of the sorter
// Accepts entries from the push side and holds them until the insertion row
// takes them, so the producer can keep pushing while the row drains a run.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_in_queue
  import sis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  // push side
  input  wire logic     push,
  input  wire in_item_t item,
  output logic          full,
  // toward the insertion row
  output logic          q_valid,
  output in_item_t      q_item,
  input  wire logic     q_pop
);

  in_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push_ok;
  logic               pop_ok;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign push_ok = push && !full;
  assign pop_ok  = q_pop && q_valid;

  // Entry storage, written on each accepted transaction
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= item;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/sis_insert_row.sv -----
// ----------------------------------------------------------------------------
// sis_insert_row: systolic insertion row of the sorter
// Every cell compares its key with the incoming one at once and either holds,
// takes its left neighbor, or takes the new entry. After the last entry the
// row shifts out toward cell 0, one sorted result per cycle while taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_insert_row
  import sis_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  // from the front queue
  input  wire logic     q_valid,
  input  wire in_item_t q_item,
  output logic          q_pop,
  // toward the output register
  output logic          d_valid,
  output out_item_t     d_item,
  input  wire logic     d_take
);

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                state;
  state_t                state_next;
  logic signed [31:0]    cell_key [CAPACITY];
  logic        [15:0]    cell_nb  [CAPACITY];
  logic        [15:0]    cell_ed  [CAPACITY];
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      fill_next;
  logic                  dropped;
  logic                  dropped_next;
  logic [CAPACITY-1:0]   gt;
  logic                  has_room;
  logic                  do_insert;
  logic                  do_shift;

  assign has_room  = (fill < CNT_W'(CAPACITY));
  assign q_pop     = (state == ST_FILL) && q_valid;
  assign do_insert = q_pop && has_room;
  assign d_valid   = (state == ST_DRAIN);
  assign do_shift  = d_valid && d_take;

  // Per-cell compare: stored key strictly greater keeps equal keys in order
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CNT_W'(i) < fill) && (cell_key[i] > q_item.key);
    end
  end

  // Head of the row is the next result
  always_comb begin
    d_item.sorted_key      = cell_key[0];
    d_item.sorted_neighbor = cell_nb[0];
    d_item.sorted_edge     = cell_ed[0];
    d_item.last_out        = (fill == CNT_W'(1));
    d_item.overflow        = dropped;
  end

  // Cell contents: insert in parallel, or shift toward cell 0 while draining
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_insert) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_key[i] <= cell_key[(i > 0) ? i - 1 : 0];
          cell_nb[i]  <= cell_nb[(i > 0) ? i - 1 : 0];
          cell_ed[i]  <= cell_ed[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || CNT_W'(i) == fill) begin
          cell_key[i] <= q_item.key;
          cell_nb[i]  <= q_item.neighbor_id;
          cell_ed[i]  <= q_item.edge_id;
        end
      end else if (do_shift && i < CAPACITY - 1) begin
        cell_key[i] <= cell_key[(i < CAPACITY - 1) ? i + 1 : i];
        cell_nb[i]  <= cell_nb[(i < CAPACITY - 1) ? i + 1 : i];
        cell_ed[i]  <= cell_ed[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  // Run control: fill count, drop flag, fill/drain sequencing
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    dropped_next = dropped;
    unique case (state)
      ST_FILL: begin
        if (q_pop) begin
          if (has_room) begin
            fill_next = fill + CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (q_item.last_in) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (do_shift) begin
          fill_next = fill - CNT_W'(1);
          if (fill == CNT_W'(1)) begin
            dropped_next = 1'b0;
            state_next   = ST_FILL;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      fill    <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      dropped <= dropped_next;
    end
  end

endmodule

`default_nettype wire

// ----- verif/stable_insertion_sorter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_insertion_sorter_test: self-checking bench for the stable sorter
// Entry runs go in through push/full and sorted results come back through
// pop/empty. A scoreboard keeps its own sorted store, predicts every result,
// and compares each popped result with the oldest prediction. Runs cover key
// extremes, equal keys, single-entry runs and runs past capacity. Both sides
// idle at random, and the result side stalls once so the front queue fills.
// ----------------------------------------------------------------------------

module stable_insertion_sorter_test;
  import sis_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RST_CYCLES = 11;
  localparam int RAND_ITEMS = 75;
  localparam int HOLD_AT    = 3;      // results taken before the long stall
  localparam int HOLD_LEN   = 300;    // cycles of the long stall
  localparam int DRAIN_WAIT = 50;     // quiet cycles after the last result
  localparam int MAX_CYCLES = 100000;
  localparam int MAX_REPORT = 10;

  // Predicts sorted runs and checks popped results against them
  class sort_scoreboard;
    logic signed [31:0] keys  [CAPACITY];
    logic        [15:0] nbrs  [CAPACITY];
    logic        [15:0] edges [CAPACITY];
    int unsigned        fill;
    bit                 dropped;
    out_item_t          expected_q[$];
    int unsigned        errors, entries, drops, runs, checked;

    function new();
      fill    = 0;
      dropped = 1'b0;
      errors  = 0;
      entries = 0;
      drops   = 0;
      runs    = 0;
      checked = 0;
    endfunction

    // Insert one accepted entry; on the last one, queue the whole sorted run
    function void note_entry(in_item_t e);
      int        pos;
      out_item_t r;
      entries++;
      if (fill < CAPACITY) begin
        pos = fill;
        // strictly greater keys move up, so equal keys keep arrival order
        while (pos > 0 && $signed(keys[pos-1]) > $signed(e.key)) begin
          keys[pos]  = keys[pos-1];
          nbrs[pos]  = nbrs[pos-1];
          edges[pos] = edges[pos-1];
          pos--;
        end
        keys[pos]  = e.key;
        nbrs[pos]  = e.neighbor_id;
        edges[pos] = e.edge_id;
        fill++;
      end else begin
        dropped = 1'b1;
        drops++;
      end
      if (e.last_in) begin
        runs++;
        for (int i = 0; i < fill; i++) begin
          r.sorted_key      = keys[i];
          r.sorted_neighbor = nbrs[i];
          r.sorted_edge     = edges[i];
          r.last_out        = (i == fill - 1);
          r.overflow        = dropped;
          expected_q.push_back(r);
        end
        fill    = 0;
        dropped = 1'b0;
      end
    endfunction

    // Compare one popped result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("%0t: unexpected result key=%0d nb=%h ed=%h last=%b ovf=%b",
                   $realtime, got.sorted_key, got.sorted_neighbor, got.sorted_edge,
                   got.last_out, got.overflow);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.sorted_key !== want.sorted_key ||
          got.sorted_neighbor !== want.sorted_neighbor ||
          got.sorted_edge !== want.sorted_edge ||
          got.last_out !== want.last_out ||
          got.overflow !== want.overflow) begin
        errors++;
        if (errors <= MAX_REPORT) begin
          $display("%0t: mismatch on result %0d", $realtime, checked);
          $display("  expected key=%0d nb=%h ed=%h last=%b ovf=%b",
                   want.sorted_key, want.sorted_neighbor, want.sorted_edge,
                   want.last_out, want.overflow);
          $display("  actual   key=%0d nb=%h ed=%h last=%b ovf=%b",
                   got.sorted_key, got.sorted_neighbor, got.sorted_edge,
                   got.last_out, got.overflow);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      push;
  in_item_t  item;
  logic      full;
  logic      empty;
  out_item_t result;
  logic      pop;

  sort_scoreboard sb;
  int unsigned    cycles;
  int unsigned    taken;
  bit             send_burst;
  bit             take_burst;

  stable_insertion_sorter u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .empty  (empty),
    .result (result),
    .pop    (pop)
  );

  // Clock and initial values of every input
  initial begin
    clk  = 1'b0;
    rst  = 1'b1;
    push = 1'b0;
    pop  = 1'b0;
    item = '0;
  end

  always #CLK_HALF clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_item_t make_entry(logic signed [31:0] k, logic [15:0] nb,
                                          logic [15:0] ed, logic lst);
    in_item_t e;
    e.key         = k;
    e.neighbor_id = nb;
    e.edge_id     = ed;
    e.last_in     = lst;
    return e;
  endfunction

  // Random key: full range, a narrow band full of ties, or an extreme
  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2:    return $signed($urandom_range(0, 6)) - 3;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0000_0000;
          default: return 32'shFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Offer one entry and hold it until the block takes it
  task automatic send_entry(input in_item_t e);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_entry(e);
  endtask

  // Pop one result; once, hold off long enough for the input to back up
  task automatic take_result();
    int gap;
    if ($urandom_range(0, 15) == 0) take_burst = ~take_burst;
    if (taken == HOLD_AT) gap = HOLD_LEN;
    else gap = take_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      pop <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pop <= 1'b1;
    @(posedge clk);
    while (empty) @(posedge clk);
    sb.check_result(result);
    taken++;
  endtask

  // Result side runs for the whole test
  initial begin
    @(negedge rst);
    forever take_result();
  end

  // Stimulus and end of test
  initial begin
    int run_len;
    int sent;
    sb         = new();
    cycles     = 0;
    taken      = 0;
    send_burst = 1'b0;
    take_burst = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: key extremes, ties with stable order, id extremes
    send_entry(make_entry(32'sh7FFF_FFFF, 16'hFFFF, 16'h0000, 1'b0));
    send_entry(make_entry(32'sh8000_0000, 16'h0000, 16'hFFFF, 1'b0));
    send_entry(make_entry(32'sh0000_0000, 16'h0001, 16'h0001, 1'b0));
    send_entry(make_entry(32'shFFFF_FFFF, 16'h0002, 16'h0002, 1'b0));
    send_entry(make_entry(32'sh0000_0000, 16'h0003, 16'h0003, 1'b0));
    send_entry(make_entry(32'shFFFF_FFFF, 16'h0004, 16'h0004, 1'b1));
    // single-entry run
    send_entry(make_entry(32'sh0001_0000, 16'hA5A5, 16'h5A5A, 1'b1));
    // run past capacity: two dropped entries, the last one carries last_in
    for (int i = 0; i < CAPACITY + 2; i++)
      send_entry(make_entry($signed(i % 5) - 2, 16'(i), 16'(16'hFFFF - i),
                            i == CAPACITY + 1));

    // Random runs, mostly short, now and then near or past capacity
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 7) == 0) run_len = $urandom_range(CAPACITY - 2, CAPACITY + 4);
      else run_len = $urandom_range(1, 8);
      for (int i = 0; i < run_len; i++)
        send_entry(make_entry(pick_key(), 16'($urandom), 16'($urandom),
                              i == run_len - 1));
      sent += run_len;
    end
    @(negedge clk);
    push <= 1'b0;

    // Drain, then allow time for any stray result
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sorted %0d runs from %0d entries, %0d dropped past capacity",
             sb.runs, sb.entries, sb.drops);
    $display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
src/sis_pkg.sv
src/sis_in_queue.sv
src/sis_insert_row.sv
src/stable_insertion_sorter.sv
verif/stable_insertion_sorter_test.sv
